>>> src/dual_pid_drive_controller_macros.svh
// Assertion helpers for the checker file.
`ifndef DUAL_PID_DRIVE_CONTROLLER_MACROS_SVH
`define DUAL_PID_DRIVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define DPDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpdc assertion failed");

// Next-cycle implication, ignored while in reset.
`define DPDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpdc assertion failed");

// Next-cycle implication that also holds across reset.
`define DPDC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpdc assertion failed");

`endif

>>> src/dpdc_pkg.sv
package dpdc_pkg;

  localparam int TGT_W      = 16;
  localparam int HEAD_W     = 16;
  localparam int GAIN_W     = 12;
  localparam int WIN_W      = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_W      = 24;
  localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN    = -(2 ** (OUT_W - 1));

  // turn error and its difference
  localparam int TE_W = HEAD_W + 1;
  localparam int TD_W = TE_W + 1;

  localparam logic [GAIN_W-1:0] LAT_KP_RST = GAIN_W'(26);
  localparam logic [GAIN_W-1:0] LAT_KD_RST = GAIN_W'(26);
  localparam logic [GAIN_W-1:0] TRN_KP_RST = GAIN_W'(179);
  localparam logic [GAIN_W-1:0] TRN_KI_RST = GAIN_W'(26);
  localparam logic [GAIN_W-1:0] TRN_KD_RST = GAIN_W'(26);
  localparam logic [WIN_W-1:0]  WIN_RST    = WIN_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_TGT = 3'd0,
    REG_TRN_TGT = 3'd1,
    REG_LAT_KP  = 3'd2,
    REG_LAT_KD  = 3'd3,
    REG_TRN_KP  = 3'd4,
    REG_TRN_KI  = 3'd5,
    REG_TRN_KD  = 3'd6,
    REG_WIN     = 3'd7
  } cfg_reg_e_t;

endpackage

>>> src/dpdc_err.sv
module dpdc_err import dpdc_pkg::*; #(
  parameter int INTEGRAL_LIMIT = 300,
  parameter int POSITION_WIDTH = 16,
  parameter int EW             = 17,
  parameter int IW             = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [POSITION_WIDTH-1:0] lpos,
  input  logic signed [POSITION_WIDTH-1:0] rpos,
  input  logic signed [HEAD_W-1:0]         heading,
  input  logic signed [TGT_W-1:0]          lat_tgt,
  input  logic signed [TGT_W-1:0]          trn_tgt,
  input  logic        [WIN_W-1:0]          win,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [EW-1:0]             lat_err,
  output logic signed [EW:0]               lat_der,
  output logic signed [TE_W-1:0]           trn_err,
  output logic signed [TD_W-1:0]           trn_der,
  output logic signed [IW-1:0]             integ
);

  localparam int PW = POSITION_WIDTH;
  localparam int SW = ((IW > TE_W) ? IW : TE_W) + 1;
  localparam logic signed [SW-1:0] LIM_POS = SW'(INTEGRAL_LIMIT);
  localparam logic signed [SW-1:0] LIM_NEG = -LIM_POS;

  logic                 v_r;
  logic signed [EW-1:0] lat_err_r, lat_err_nxt;
  logic signed [EW:0]   lat_der_r;
  logic signed [TE_W-1:0] trn_err_r, trn_err_nxt;
  logic signed [TD_W-1:0] trn_der_r;
  logic signed [IW-1:0] integ_r, integ_nxt;

  logic signed [PW:0]   sum_lr;
  logic signed [PW:0]   avg_full;
  logic signed [PW-1:0] avg;
  logic [TE_W-1:0]      mag;
  logic signed [SW-1:0] acc;
  logic                 load;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    sum_lr      = (PW+1)'(lpos) + (PW+1)'(rpos);
    // halve, truncating toward zero
    avg_full    = (sum_lr + $signed({{PW{1'b0}}, sum_lr[PW]})) >>> 1;
    avg         = avg_full[PW-1:0];
    lat_err_nxt = EW'(lat_tgt) - EW'(avg);
    trn_err_nxt = TE_W'(heading) - TE_W'(trn_tgt);
    mag         = trn_err_nxt[TE_W-1] ? TE_W'(-trn_err_nxt) : TE_W'(trn_err_nxt);
    acc         = SW'(integ_r) + SW'(trn_err_nxt);
    if (mag < TE_W'(win)) begin
      if (acc > LIM_POS) begin
        integ_nxt = IW'(LIM_POS);
      end else if (acc < LIM_NEG) begin
        integ_nxt = IW'(LIM_NEG);
      end else begin
        integ_nxt = IW'(acc);
      end
    end else begin
      integ_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      lat_err_r <= '0;
      trn_err_r <= '0;
      integ_r   <= '0;
    end else begin
      if (up_ready) begin
        v_r <= up_valid;
      end
      if (load) begin
        lat_err_r <= lat_err_nxt;
        trn_err_r <= trn_err_nxt;
        integ_r   <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lat_der_r <= (EW+1)'(lat_err_nxt) - (EW+1)'(lat_err_r);
      trn_der_r <= TD_W'(trn_err_nxt) - TD_W'(trn_err_r);
    end
  end

  assign dn_valid = v_r;
  assign lat_err  = lat_err_r;
  assign lat_der  = lat_der_r;
  assign trn_err  = trn_err_r;
  assign trn_der  = trn_der_r;
  assign integ    = integ_r;

endmodule

>>> src/dpdc_mul.sv
module dpdc_mul import dpdc_pkg::*; #(
  parameter int EW = 17,
  parameter int IW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [EW-1:0]       lat_err,
  input  logic signed [EW:0]         lat_der,
  input  logic signed [TE_W-1:0]     trn_err,
  input  logic signed [TD_W-1:0]     trn_der,
  input  logic signed [IW-1:0]       integ,
  input  logic        [GAIN_W-1:0]   lat_kp,
  input  logic        [GAIN_W-1:0]   lat_kd,
  input  logic        [GAIN_W-1:0]   trn_kp,
  input  logic        [GAIN_W-1:0]   trn_ki,
  input  logic        [GAIN_W-1:0]   trn_kd,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic signed [EW+GAIN_W:0]   lat_p,
  output logic signed [EW+GAIN_W+1:0] lat_d,
  output logic signed [TE_W+GAIN_W:0] trn_p,
  output logic signed [TD_W+GAIN_W:0] trn_d,
  output logic signed [IW+GAIN_W:0]   trn_i
);

  logic v_r;
  logic load;
  logic signed [EW+GAIN_W:0]   lat_p_r;
  logic signed [EW+GAIN_W+1:0] lat_d_r;
  logic signed [TE_W+GAIN_W:0] trn_p_r;
  logic signed [TD_W+GAIN_W:0] trn_d_r;
  logic signed [IW+GAIN_W:0]   trn_i_r;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lat_p_r <= lat_err * $signed({1'b0, lat_kp});
      lat_d_r <= lat_der * $signed({1'b0, lat_kd});
      trn_p_r <= trn_err * $signed({1'b0, trn_kp});
      trn_d_r <= trn_der * $signed({1'b0, trn_kd});
      trn_i_r <= integ * $signed({1'b0, trn_ki});
    end
  end

  assign dn_valid = v_r;
  assign lat_p    = lat_p_r;
  assign lat_d    = lat_d_r;
  assign trn_p    = trn_p_r;
  assign trn_d    = trn_d_r;
  assign trn_i    = trn_i_r;

endmodule

>>> src/dpdc_sum.sv
module dpdc_sum import dpdc_pkg::*; #(
  parameter int EW = 17,
  parameter int IW = 10,
  parameter int FW = 34
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [EW+GAIN_W:0]   lat_p,
  input  logic signed [EW+GAIN_W+1:0] lat_d,
  input  logic signed [TE_W+GAIN_W:0] trn_p,
  input  logic signed [TD_W+GAIN_W:0] trn_d,
  input  logic signed [IW+GAIN_W:0]   trn_i,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [FW-1:0]        lat_pwr,
  output logic signed [FW-1:0]        trn_pwr
);

  logic v_r;
  logic load;
  logic signed [FW-1:0] lat_pwr_r, trn_pwr_r;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lat_pwr_r <= FW'(lat_p) + FW'(lat_d);
      trn_pwr_r <= FW'(trn_p) + FW'(trn_d) + FW'(trn_i);
    end
  end

  assign dn_valid = v_r;
  assign lat_pwr  = lat_pwr_r;
  assign trn_pwr  = trn_pwr_r;

endmodule

>>> src/dual_pid_drive_controller.sv
// Two-loop drive controller for a differential base, one control tick per beat.
// Input channel (in_valid/in_ready): left and right wheel positions and heading.
// Output channel (out_valid/out_ready): left and right motor drive, signed Q.8,
// saturated to 24 bits. Exactly one output beat per input beat, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no beat is in flight.
// Pipeline: input register, error/integral stage, multiply stage, sum stage,
// saturating output register. Throughput is one beat per cycle while
// out_ready stays high. The turn integral and previous errors are updated
// in the error stage as each beat is taken, so beats may follow back to back.
// Each stage has its own valid bit and takes a new beat whenever it is empty
// or its content moves on, so a stalled receiver holds only full stages and
// empty ones fill; in_ready drops when all stages are full and out_ready low.
// Reset (synchronous, active low) empties the pipe, zeroes the loop state
// and restores the default gains, targets and integral window.
module dual_pid_drive_controller import dpdc_pkg::*; #(
  parameter int INTEGRAL_LIMIT = 300,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [POSITION_WIDTH-1:0] in_left_position,
  input  logic signed [POSITION_WIDTH-1:0] in_right_position,
  input  logic signed [HEAD_W-1:0]         in_heading,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [OUT_W-1:0]          out_left_drive,
  output logic signed [OUT_W-1:0]          out_right_drive,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int EW = ((POSITION_WIDTH > TGT_W) ? POSITION_WIDTH : TGT_W) + 1;
  localparam int IW = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam int FW = EW + GAIN_W + 5;
  localparam logic signed [FW-1:0] SAT_HI = FW'(OUT_MAX);
  localparam logic signed [FW-1:0] SAT_LO = FW'(OUT_MIN);

  logic signed [TGT_W-1:0] lat_tgt_r, trn_tgt_r;
  logic [GAIN_W-1:0] lat_kp_r, lat_kd_r, trn_kp_r, trn_ki_r, trn_kd_r;
  logic [WIN_W-1:0]  win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_tgt_r <= '0;
      trn_tgt_r <= '0;
      lat_kp_r  <= LAT_KP_RST;
      lat_kd_r  <= LAT_KD_RST;
      trn_kp_r  <= TRN_KP_RST;
      trn_ki_r  <= TRN_KI_RST;
      trn_kd_r  <= TRN_KD_RST;
      win_r     <= WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e_t'(cfg_index))
        REG_LAT_TGT: lat_tgt_r <= cfg_data[TGT_W-1:0];
        REG_TRN_TGT: trn_tgt_r <= cfg_data[TGT_W-1:0];
        REG_LAT_KP:  lat_kp_r  <= cfg_data[GAIN_W-1:0];
        REG_LAT_KD:  lat_kd_r  <= cfg_data[GAIN_W-1:0];
        REG_TRN_KP:  trn_kp_r  <= cfg_data[GAIN_W-1:0];
        REG_TRN_KI:  trn_ki_r  <= cfg_data[GAIN_W-1:0];
        REG_TRN_KD:  trn_kd_r  <= cfg_data[GAIN_W-1:0];
        REG_WIN:     win_r     <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                             a_v_r;
  logic                             a_rdy;
  logic signed [POSITION_WIDTH-1:0] a_lpos_r, a_rpos_r;
  logic signed [HEAD_W-1:0]         a_head_r;

  logic b_rdy, b_v;
  logic signed [EW-1:0]   b_lat_err;
  logic signed [EW:0]     b_lat_der;
  logic signed [TE_W-1:0] b_trn_err;
  logic signed [TD_W-1:0] b_trn_der;
  logic signed [IW-1:0]   b_integ;

  logic c_rdy, c_v;
  logic signed [EW+GAIN_W:0]   c_lat_p;
  logic signed [EW+GAIN_W+1:0] c_lat_d;
  logic signed [TE_W+GAIN_W:0] c_trn_p;
  logic signed [TD_W+GAIN_W:0] c_trn_d;
  logic signed [IW+GAIN_W:0]   c_trn_i;

  logic d_rdy, d_v;
  logic signed [FW-1:0] d_lat_pwr, d_trn_pwr;

  logic e_rdy;
  logic out_valid_r;
  logic signed [OUT_W-1:0] left_r, right_r;
  logic signed [FW-1:0] left_sum, right_sum;
  logic signed [OUT_W-1:0] left_sat, right_sat;

  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_lpos_r <= in_left_position;
      a_rpos_r <= in_right_position;
      a_head_r <= in_heading;
    end
  end

  dpdc_err #(
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
    .POSITION_WIDTH (POSITION_WIDTH),
    .EW             (EW),
    .IW             (IW)
  ) u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_v_r),
    .up_ready (b_rdy),
    .lpos     (a_lpos_r),
    .rpos     (a_rpos_r),
    .heading  (a_head_r),
    .lat_tgt  (lat_tgt_r),
    .trn_tgt  (trn_tgt_r),
    .win      (win_r),
    .dn_valid (b_v),
    .dn_ready (c_rdy),
    .lat_err  (b_lat_err),
    .lat_der  (b_lat_der),
    .trn_err  (b_trn_err),
    .trn_der  (b_trn_der),
    .integ    (b_integ)
  );

  dpdc_mul #(
    .EW (EW),
    .IW (IW)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_v),
    .up_ready (c_rdy),
    .lat_err  (b_lat_err),
    .lat_der  (b_lat_der),
    .trn_err  (b_trn_err),
    .trn_der  (b_trn_der),
    .integ    (b_integ),
    .lat_kp   (lat_kp_r),
    .lat_kd   (lat_kd_r),
    .trn_kp   (trn_kp_r),
    .trn_ki   (trn_ki_r),
    .trn_kd   (trn_kd_r),
    .dn_valid (c_v),
    .dn_ready (d_rdy),
    .lat_p    (c_lat_p),
    .lat_d    (c_lat_d),
    .trn_p    (c_trn_p),
    .trn_d    (c_trn_d),
    .trn_i    (c_trn_i)
  );

  dpdc_sum #(
    .EW (EW),
    .IW (IW),
    .FW (FW)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_v),
    .up_ready (d_rdy),
    .lat_p    (c_lat_p),
    .lat_d    (c_lat_d),
    .trn_p    (c_trn_p),
    .trn_d    (c_trn_d),
    .trn_i    (c_trn_i),
    .dn_valid (d_v),
    .dn_ready (e_rdy),
    .lat_pwr  (d_lat_pwr),
    .trn_pwr  (d_trn_pwr)
  );

  // combine and saturate into the output register
  always_comb begin
    left_sum  = d_lat_pwr - d_trn_pwr;
    right_sum = d_lat_pwr + d_trn_pwr;
    if (left_sum > SAT_HI) begin
      left_sat = OUT_W'(SAT_HI);
    end else if (left_sum < SAT_LO) begin
      left_sat = OUT_W'(SAT_LO);
    end else begin
      left_sat = OUT_W'(left_sum);
    end
    if (right_sum > SAT_HI) begin
      right_sat = OUT_W'(SAT_HI);
    end else if (right_sum < SAT_LO) begin
      right_sat = OUT_W'(SAT_LO);
    end else begin
      right_sat = OUT_W'(right_sum);
    end
  end

  assign e_rdy = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_rdy) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d_v && e_rdy) begin
      left_r  <= left_sat;
      right_r <= right_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;

endmodule

>>> src/dpdc_checker.sv
`include "dual_pid_drive_controller_macros.svh"

module dpdc_checker import dpdc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_left_drive,
  input logic signed [OUT_W-1:0] out_right_drive
);

  `DPDC_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)
  `DPDC_ASSERT_NOW(a_empty_takes_input, !out_valid, in_ready)
  `DPDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `DPDC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_left_drive, out_right_drive}))

endmodule

bind dual_pid_drive_controller dpdc_checker u_dpdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_left_drive  (out_left_drive),
  .out_right_drive (out_right_drive)
);
